>>> src/vcs_pkg.sv
// vcs_pkg: shared types and constants for the six-axis velocity command smoother
// holds beat structs, op and register index codes, fixed-point widths and reset values
// no dependencies
`default_nettype none

package vcs_pkg;

    // axis layout and fixed-point format
    localparam int AXES          = 6;
    localparam int LINEAR_AXES   = 3;
    localparam int VALUE_WIDTH   = 24;
    localparam int AGE_WIDTH_DEF = 16;

    // configuration register widths
    localparam int TMO_W    = 16;
    localparam int LIM_W    = VALUE_WIDTH - 1;
    localparam int ALPHA_W  = 17;
    localparam int CFG_W    = LIM_W;
    localparam int CFG_IDX_W = 3;

    // filter coefficient format, Q1.16
    localparam int ALPHA_FRAC = 16;

    // bounds applied on use
    localparam logic [TMO_W-1:0]   TIMEOUT_MIN = TMO_W'(20);
    localparam logic [ALPHA_W-1:0] ALPHA_MIN   = ALPHA_W'(655);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);

    // register reset values
    localparam logic [TMO_W-1:0]   RST_TIMEOUT    = TMO_W'(200);
    localparam logic [LIM_W-1:0]   RST_LIN_VEL    = LIM_W'(31457);
    localparam logic [LIM_W-1:0]   RST_ANG_VEL    = LIM_W'(157286);
    localparam logic [LIM_W-1:0]   RST_LIN_STEP   = LIM_W'(63);
    localparam logic [LIM_W-1:0]   RST_ANG_STEP   = LIM_W'(262);
    localparam logic [ALPHA_W-1:0] RST_ALPHA      = ALPHA_W'(3277);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    // input beat op codes
    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_ACT   = 2'd2,
        OP_DEACT = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT  = 3'd0,
        CFG_LIN_VEL  = 3'd1,
        CFG_ANG_VEL  = 3'd2,
        CFG_LIN_STEP = 3'd3,
        CFG_ANG_STEP = 3'd4,
        CFG_ALPHA    = 3'd5
    } t_cfg_idx;

    // input beat
    typedef struct packed {
        logic [1:0] op;
        t_value     lin_x;
        t_value     lin_y;
        t_value     lin_z;
        t_value     ang_x;
        t_value     ang_y;
        t_value     ang_z;
    } t_in_beat;

    // output beat
    typedef struct packed {
        t_value out_lin_x;
        t_value out_lin_y;
        t_value out_lin_z;
        t_value out_ang_x;
        t_value out_ang_y;
        t_value out_ang_z;
        logic   command_fresh;
    } t_out_beat;

    // per-beat control from the top level to every lane
    typedef struct packed {
        logic cmd_we;
        logic tick;
        logic clear;
        logic fresh;
    } t_lane_ctl;

endpackage

`default_nettype wire

>>> src/vcs_lane.sv
// vcs_lane: one axis of the smoother, held command plus low-pass and slew limit step
// depends on vcs_pkg
`default_nettype none

module vcs_lane import vcs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_ctl          i_ctl,
    input  wire t_value             i_cmd,
    input  wire logic [LIM_W-1:0]   i_vel_lim,
    input  wire logic [LIM_W-1:0]   i_step_lim,
    input  wire logic [ALPHA_W-1:0] i_alpha,
    output t_value                  o_next
);

    localparam int CW = VALUE_WIDTH + 1;
    localparam int PW = CW + ALPHA_W + 1;
    localparam int DW = PW - ALPHA_FRAC;
    localparam logic signed [DW-1:0] SAT_HI =
        {{(DW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO =
        {{(DW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

    t_value r_held, n_held;
    t_value r_smooth;

    logic signed [CW-1:0]      cmd_x, lim_pos, lim_neg, held_sat;
    logic signed [CW-1:0]      target_x, smooth_x, diff;
    logic signed [ALPHA_W:0]   alpha_s;
    logic signed [PW-1:0]      prod;
    logic signed [DW-1:0]      delta, step_pos, step_neg, delta_cl, base_x, sum;

    // command saturation to the axis velocity limit
    always_comb begin
        cmd_x   = {i_cmd[VALUE_WIDTH-1], i_cmd};
        lim_pos = {2'b00, i_vel_lim};
        lim_neg = -lim_pos;
        if (cmd_x > lim_pos) begin
            held_sat = lim_pos;
        end else if (cmd_x < lim_neg) begin
            held_sat = lim_neg;
        end else begin
            held_sat = cmd_x;
        end
        n_held = held_sat[VALUE_WIDTH-1:0];
    end

    // low-pass step: floor(alpha * error / 2^16), then slew clamp and saturating add
    always_comb begin
        target_x = i_ctl.fresh ? {r_held[VALUE_WIDTH-1], r_held} : '0;
        smooth_x = {r_smooth[VALUE_WIDTH-1], r_smooth};
        diff     = target_x - smooth_x;
        alpha_s  = {1'b0, i_alpha};
        prod     = diff * alpha_s;
        delta    = prod[PW-1:ALPHA_FRAC];
        step_pos = {{(DW-LIM_W){1'b0}}, i_step_lim};
        step_neg = -step_pos;
        if (delta > step_pos) begin
            delta_cl = step_pos;
        end else if (delta < step_neg) begin
            delta_cl = step_neg;
        end else begin
            delta_cl = delta;
        end
        base_x = {{(DW-VALUE_WIDTH){r_smooth[VALUE_WIDTH-1]}}, r_smooth};
        sum    = base_x + delta_cl;
        if (sum > SAT_HI) begin
            o_next = SAT_HI[VALUE_WIDTH-1:0];
        end else if (sum < SAT_LO) begin
            o_next = SAT_LO[VALUE_WIDTH-1:0];
        end else begin
            o_next = sum[VALUE_WIDTH-1:0];
        end
    end

    // axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_smooth <= '0;
        end else if (i_ctl.clear) begin
            r_held   <= '0;
            r_smooth <= '0;
        end else begin
            if (i_ctl.cmd_we) begin
                r_held <= n_held;
            end
            if (i_ctl.tick) begin
                r_smooth <= o_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/six_axis_velocity_command_smoother_core.sv
// six_axis_velocity_command_smoother_core: top level, command aging, register file,
// six axis lanes and the output register that merges them
// depends on vcs_pkg and vcs_lane
`default_nettype none

// Takes one input beat per clock while o_in_ready is high. A command beat saturates
// and stores the six axes, activate and deactivate clear the stores, and a tick beat
// produces one output beat with the six smoothed values on the cycle after it is
// accepted. Each axis has its own lane with one multiplier, so the per-tick multiply,
// slew clamp and saturating add of all six axes are combinational and ticks may
// follow back to back. o_in_ready is high whenever the output register is empty or
// is being taken in the same cycle. Register writes take effect at the next edge and
// are meant for idle periods only; unknown register indexes are ignored.

module six_axis_velocity_command_smoother_core import vcs_pkg::*; #(
    parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_beat             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_beat                 o_out_data
);

    localparam int CMP_W = (AGE_WIDTH > TMO_W) ? AGE_WIDTH : TMO_W;

    logic [TMO_W-1:0]   r_timeout;
    logic [LIM_W-1:0]   r_lin_vel, r_ang_vel, r_lin_step, r_ang_step;
    logic [ALPHA_W-1:0] r_alpha;

    logic [AGE_WIDTH-1:0] r_age, n_age_tick;
    logic                 r_seen, r_enabled;
    logic                 r_out_valid;
    t_out_beat            r_out_data;

    logic               accept, is_cmd, is_tick, is_act, is_deact, fresh;
    logic [TMO_W-1:0]   tmo_eff;
    logic [ALPHA_W-1:0] alpha_eff;
    t_lane_ctl          lane_ctl;
    t_value             lane_cmd  [AXES];
    t_value             lane_next [AXES];

    // input handshake and op decode
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        is_cmd   = 1'b0;
        is_tick  = 1'b0;
        is_act   = 1'b0;
        is_deact = 1'b0;
        unique case (t_op'(i_in_data.op))
            OP_CMD:   is_cmd   = accept;
            OP_TICK:  is_tick  = accept;
            OP_ACT:   is_act   = accept;
            OP_DEACT: is_deact = accept;
            default: ;
        endcase
    end

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= RST_TIMEOUT;
            r_lin_vel  <= RST_LIN_VEL;
            r_ang_vel  <= RST_ANG_VEL;
            r_lin_step <= RST_LIN_STEP;
            r_ang_step <= RST_ANG_STEP;
            r_alpha    <= RST_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TMO_W-1:0];
                CFG_LIN_VEL:  r_lin_vel  <= i_cfg_data[LIM_W-1:0];
                CFG_ANG_VEL:  r_ang_vel  <= i_cfg_data[LIM_W-1:0];
                CFG_LIN_STEP: r_lin_step <= i_cfg_data[LIM_W-1:0];
                CFG_ANG_STEP: r_ang_step <= i_cfg_data[LIM_W-1:0];
                CFG_ALPHA:    r_alpha    <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // bounds on the timeout and the coefficient
    always_comb begin
        tmo_eff = (r_timeout < TIMEOUT_MIN) ? TIMEOUT_MIN : r_timeout;
        if (r_alpha < ALPHA_MIN) begin
            alpha_eff = ALPHA_MIN;
        end else if (r_alpha > ALPHA_ONE) begin
            alpha_eff = ALPHA_ONE;
        end else begin
            alpha_eff = r_alpha;
        end
    end

    // command aging, saturating at all ones
    assign n_age_tick = (r_age != '1) ? r_age + AGE_WIDTH'(1) : r_age;
    assign fresh      = r_enabled && r_seen && (CMP_W'(n_age_tick) <= CMP_W'(tmo_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age     <= '0;
            r_seen    <= 1'b0;
            r_enabled <= 1'b0;
        end else begin
            if (is_cmd) begin
                r_age  <= '0;
                r_seen <= 1'b1;
            end
            if (is_tick) begin
                r_age <= n_age_tick;
            end
            if (is_act) begin
                r_age     <= '0;
                r_seen    <= 1'b0;
                r_enabled <= 1'b1;
            end
            if (is_deact) begin
                r_enabled <= 1'b0;
            end
        end
    end

    // lane control and command fan-out
    assign lane_ctl.cmd_we = is_cmd;
    assign lane_ctl.tick   = is_tick;
    assign lane_ctl.clear  = is_act || is_deact;
    assign lane_ctl.fresh  = fresh;

    assign lane_cmd[0] = i_in_data.lin_x;
    assign lane_cmd[1] = i_in_data.lin_y;
    assign lane_cmd[2] = i_in_data.lin_z;
    assign lane_cmd[3] = i_in_data.ang_x;
    assign lane_cmd[4] = i_in_data.ang_y;
    assign lane_cmd[5] = i_in_data.ang_z;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        vcs_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_cmd      (lane_cmd[g]),
            .i_vel_lim  ((g < LINEAR_AXES) ? r_lin_vel  : r_ang_vel),
            .i_step_lim ((g < LINEAR_AXES) ? r_lin_step : r_ang_step),
            .i_alpha    (alpha_eff),
            .o_next     (lane_next[g])
        );
    end

    // output register merges the lanes on every tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_tick) begin
            r_out_data.out_lin_x     <= lane_next[0];
            r_out_data.out_lin_y     <= lane_next[1];
            r_out_data.out_lin_z     <= lane_next[2];
            r_out_data.out_ang_x     <= lane_next[3];
            r_out_data.out_ang_y     <= lane_next[4];
            r_out_data.out_ang_z     <= lane_next[5];
            r_out_data.command_fresh <= fresh;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> src/vcs_checker.sv
// vcs_checker: port-level checks on the smoother top level, attached by bind
// depends on vcs_pkg and six_axis_velocity_command_smoother_core
`default_nettype none

module vcs_checker import vcs_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_ready,
    input wire t_in_beat             i_in_data,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire t_out_beat            o_out_data
);

    // a stalled output beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // every accepted tick yields an output beat on the next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.op == OP_TICK) |=> o_out_valid)
        else $error("tick gave no output beat");

    // command and activation beats never invent an output beat
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.op != OP_TICK) && !o_out_valid
        |=> !o_out_valid)
        else $error("output beat without a tick");

endmodule

bind six_axis_velocity_command_smoother_core vcs_checker u_vcs_checker (.*);

`default_nettype wire
